FILE: sv/kgc_pkg.sv
// kgc_pkg: shared constants, needle tables and types for keyword_group_counter
// no dependencies; used by every module of the block

package kgc_pkg;

   localparam int NEEDLES           = 33;
   localparam int GROUPS            = 8;
   localparam int WINDOW            = 20;
   localparam int SPAN              = WINDOW + 1;
   localparam int GUARD_BITS        = 5;
   localparam int TALLY_INC_BITS    = 3;
   localparam int FIFO_DEPTH        = 4;
   localparam int LINE_BITS_DEFAULT = 20;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [2:0] LAST_GROUP = 3'(GROUPS - 1);
   localparam logic [7:0] NEWLINE    = 8'h0a;

   // needle text, right-aligned: last character in bits [7:0], zero padded
   localparam logic [8*SPAN-1:0] NEEDLE_TEXT [NEEDLES] = '{
      "rand(", {"random", "_device"}, "mt19937", "uniform_",
      {"sleep", "_for"}, {"sleep", "_until"}, "usleep", {"wait", "_for"}, "wait_until",
      "nanosleep",
      "time(", "chrono::", {"system", "_clock"}, {"steady", "_clock"},
      {"high_", "resolution_clock"}, "now()",
      "getenv(", "setenv(", "putenv(",
      "std::thread", "pthread_", "std::async", {"condition", "_variable"}, "mutex",
      "atomic<", {"std::this", "_thread"},
      "nullptr", "NULL",
      "/ 0", "/0", "% 0", "%0",
      "["
   };

   localparam logic [GUARD_BITS:0] NEEDLE_LEN [NEEDLES] = '{
      6'd5, 6'd13, 6'd7, 6'd8,
      6'd9, 6'd11, 6'd6, 6'd8, 6'd10, 6'd9,
      6'd5, 6'd8, 6'd12, 6'd12, 6'd21, 6'd5,
      6'd7, 6'd7, 6'd7,
      6'd11, 6'd8, 6'd10, 6'd18, 6'd5, 6'd7, 6'd16,
      6'd7, 6'd4,
      6'd3, 6'd2, 6'd3, 6'd2,
      6'd1
   };

   localparam logic [2:0] NEEDLE_GROUP [NEEDLES] = '{
      3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5,
      3'd6, 3'd6, 3'd6, 3'd6,
      3'd7
   };

   // needles whose first line may stand as the group's line
   localparam logic [NEEDLES-1:0] NEEDLE_REPORTS = {
      1'b1, 3'b000, 1'b1, 1'b0, 1'b1, {26{1'b1}}
   };

   typedef struct packed {
      logic [NEEDLES-1:0] hits;
      logic               newline;
      logic               last;
   } entry_type;

endpackage

FILE: sv/kgc_front.sv
// kgc_front: byte window and parallel needle comparators
// depends on kgc_pkg; feeds one classified item per accepted byte

module kgc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output kgc_pkg::entry_type  entry
);

   logic [7:0] recent_ff [kgc_pkg::WINDOW];
   logic [7:0] recent_in [kgc_pkg::WINDOW];
   logic [8*kgc_pkg::SPAN-1:0] win;
   logic [kgc_pkg::NEEDLES-1:0] hits;

   always_comb begin
      win[7:0] = text_byte;
      for (int i = 0; i < kgc_pkg::WINDOW; i++) begin
         win[8*(i+1) +: 8] = recent_ff[i];
      end
   end

   always_comb begin
      for (int k = 0; k < kgc_pkg::NEEDLES; k++) begin
         hits[k] = 1'b1;
         for (int p = 0; p < kgc_pkg::SPAN; p++) begin
            if (p < int'(kgc_pkg::NEEDLE_LEN[k]) &&
                win[8*p +: 8] != kgc_pkg::NEEDLE_TEXT[k][8*p +: 8]) begin
               hits[k] = 1'b0;
            end
         end
      end
   end

   assign entry.hits    = hits;
   assign entry.newline = (text_byte == kgc_pkg::NEWLINE);
   assign entry.last    = end_of_text;

   always_comb begin
      recent_in = recent_ff;
      if (take) begin
         if (end_of_text) begin
            recent_in = '{default: 8'd0};
         end else begin
            recent_in[0] = text_byte;
            for (int i = 1; i < kgc_pkg::WINDOW; i++) begin
               recent_in[i] = recent_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '{default: 8'd0};
      end else begin
         recent_ff <= recent_in;
      end
   end

endmodule

FILE: sv/kgc_fifo.sv
// kgc_fifo: short queue of classified items between front and back
// depends on kgc_pkg for the entry type and depth

module kgc_fifo #(
   parameter int DEPTH = kgc_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kgc_pkg::entry_type  push_entry,
   input  logic                pop,
   output kgc_pkg::entry_type  head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   kgc_pkg::entry_type        slot_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]       fill_ff, fill_in;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
      bump = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign head  = slot_ff[rd_ff];
   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == CNT_BITS'(DEPTH));

   always_comb begin
      wr_in   = push ? bump(wr_ff) : wr_ff;
      rd_in   = pop ? bump(rd_ff) : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: sv/kgc_back.sv
// kgc_back: per-needle guards, first lines, group tallies and result sequencer
// depends on kgc_pkg; takes items from kgc_fifo, drives the result channel

module kgc_back #(
   parameter int LINE_BITS  = kgc_pkg::LINE_BITS_DEFAULT,
   parameter int COUNT_BITS = kgc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kgc_pkg::entry_type    head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_group_index,
   output logic [COUNT_BITS-1:0] rsp_match_count,
   output logic [LINE_BITS-1:0]  rsp_first_line,
   output logic                  rsp_last_group
);

   localparam int N = kgc_pkg::NEEDLES;
   localparam int G = kgc_pkg::GROUPS;
   localparam int GB = kgc_pkg::GUARD_BITS;

   logic [GB-1:0]         guard_ff [N];
   logic [GB-1:0]         guard_in [N];
   logic [LINE_BITS-1:0]  fl_ff [N];
   logic [LINE_BITS-1:0]  fl_in [N];
   logic [COUNT_BITS-1:0] tally_ff [G];
   logic [COUNT_BITS-1:0] tally_in [G];
   logic [kgc_pkg::TALLY_INC_BITS-1:0] inc [G];
   logic [COUNT_BITS:0]   sum [G];
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [LINE_BITS-1:0]  grp_line [G];
   logic [COUNT_BITS-1:0] counts_ff [G];
   logic [LINE_BITS-1:0]  lines_ff [G];
   logic                  busy_ff;
   logic [2:0]            grp_ff;
   logic                  rsp_take;
   logic                  emit_done;

   assign rsp_take  = busy_ff && !rsp_stall;
   assign emit_done = rsp_take && (grp_ff == kgc_pkg::LAST_GROUP);
   assign pop       = !empty && (!head.last || !busy_ff || emit_done);

   always_comb begin
      guard_in = guard_ff;
      fl_in    = fl_ff;
      line_in  = line_ff;
      inc      = '{default: '0};
      for (int k = 0; k < N; k++) begin
         if (head.hits[k] && fl_ff[k] == '0) begin
            fl_in[k] = line_ff;
         end
         if (guard_ff[k] != '0) begin
            guard_in[k] = guard_ff[k] - GB'(1);
         end else if (head.hits[k]) begin
            inc[kgc_pkg::NEEDLE_GROUP[k]] = inc[kgc_pkg::NEEDLE_GROUP[k]] + 3'd1;
            guard_in[k] = GB'(kgc_pkg::NEEDLE_LEN[k] - 6'd1);
         end
      end
      for (int g = 0; g < G; g++) begin
         sum[g]      = {1'b0, tally_ff[g]} + (COUNT_BITS+1)'(inc[g]);
         tally_in[g] = sum[g][COUNT_BITS] ? '1 : sum[g][COUNT_BITS-1:0];
      end
      if (head.newline && !(&line_ff)) begin
         line_in = line_ff + LINE_BITS'(1);
      end
   end

   // reported line: lowest reporting needle of the group that has occurred
   always_comb begin
      for (int g = 0; g < G; g++) begin
         grp_line[g] = '0;
         for (int k = N - 1; k >= 0; k--) begin
            if (kgc_pkg::NEEDLE_GROUP[k] == 3'(g) && kgc_pkg::NEEDLE_REPORTS[k] &&
                fl_in[k] != '0) begin
               grp_line[g] = fl_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff <= '{default: '0};
         fl_ff    <= '{default: '0};
         tally_ff <= '{default: '0};
         line_ff  <= LINE_BITS'(1);
         busy_ff  <= 1'b0;
         grp_ff   <= '0;
      end else begin
         if (rsp_take) begin
            if (emit_done) begin
               busy_ff <= 1'b0;
            end else begin
               grp_ff <= grp_ff + 3'd1;
            end
         end
         if (pop) begin
            if (head.last) begin
               guard_ff <= '{default: '0};
               fl_ff    <= '{default: '0};
               tally_ff <= '{default: '0};
               line_ff  <= LINE_BITS'(1);
               busy_ff  <= 1'b1;
               grp_ff   <= '0;
            end else begin
               guard_ff <= guard_in;
               fl_ff    <= fl_in;
               tally_ff <= tally_in;
               line_ff  <= line_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last) begin
         counts_ff <= tally_in;
         lines_ff  <= grp_line;
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_group_index = grp_ff;
   assign rsp_match_count = counts_ff[grp_ff];
   assign rsp_first_line  = lines_ff[grp_ff];
   assign rsp_last_group  = (grp_ff == kgc_pkg::LAST_GROUP);

endmodule

FILE: sv/keyword_group_counter.sv
// keyword_group_counter: top level, counts keyword needles of source text by group
// depends on kgc_pkg, kgc_front, kgc_fifo, kgc_back
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | text_byte, end_of_text
//   rsp_    | out       | rsp_valid/rsp_stall | group_index, match_count, first_line, last_group
//
// one byte is taken every cycle while the item queue has room; all 33 comparators
// work on the window in the cycle a byte arrives
// the eight results of a text leave back to back in group order unless stalled,
// while bytes of the next text keep flowing into the back end
// a final byte waits in the queue only while the previous eight results are draining
// reset is synchronous and active high; it clears the window, tallies and queue

module keyword_group_counter #(
   parameter int LINE_BITS  = kgc_pkg::LINE_BITS_DEFAULT,
   parameter int COUNT_BITS = kgc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_group_index,
   output logic [COUNT_BITS-1:0] rsp_match_count,
   output logic [LINE_BITS-1:0]  rsp_first_line,
   output logic                  rsp_last_group
);

   kgc_pkg::entry_type front_entry;
   kgc_pkg::entry_type head;
   logic               take;
   logic               full;
   logic               empty;
   logic               pop;

   // queue full is the only back-pressure on bytes
   assign req_stall = full;
   assign take      = req_valid && !full;

   // front end: window and comparators
   kgc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .entry       (front_entry)
   );

   // classified items wait here so either side may stall alone
   kgc_fifo #(
      .DEPTH (kgc_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // back end: counting and result sequencing
   kgc_back #(
      .LINE_BITS  (LINE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_group_index (rsp_group_index),
      .rsp_match_count (rsp_match_count),
      .rsp_first_line  (rsp_first_line),
      .rsp_last_group  (rsp_last_group)
   );

endmodule

FILE: sv/kgc_checker.sv
// kgc_checker: port-level checks on the result channel of keyword_group_counter
// depends on kgc_pkg and the top level's ports; bound below

module kgc_checker #(
   parameter int LINE_BITS  = kgc_pkg::LINE_BITS_DEFAULT,
   parameter int COUNT_BITS = kgc_pkg::COUNT_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [2:0]            rsp_group_index,
   input logic [COUNT_BITS-1:0] rsp_match_count,
   input logic [LINE_BITS-1:0]  rsp_first_line,
   input logic                  rsp_last_group
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_group_index) &&
      $stable(rsp_match_count) && $stable(rsp_first_line))
      else $error("result item changed while stalled");

   a_group_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_group |=>
      rsp_valid && rsp_group_index == $past(rsp_group_index) + 3'd1)
      else $error("groups not sent in sequence");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_group == (rsp_group_index == kgc_pkg::LAST_GROUP)))
      else $error("last group flag on wrong group");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind keyword_group_counter kgc_checker #(
   .LINE_BITS  (LINE_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_group_index (rsp_group_index),
   .rsp_match_count (rsp_match_count),
   .rsp_first_line  (rsp_first_line),
   .rsp_last_group  (rsp_last_group)
);
